@@ rtl/core/amt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants for the adaptive mean threshold block.
// ----------------------------------------------------------------------------
package amt_pkg;

    localparam int unsigned CFG_W = 11;
    localparam int unsigned IDX_W = 2;
    localparam int unsigned INT_W = 28;
    localparam int unsigned RSUM_W = 18;
    localparam int unsigned GRAY_W = 8;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_HALF   = 2'd2;

    // window corner selects for the integral store read
    localparam logic [1:0] CRN_Y2X2 = 2'd0;
    localparam logic [1:0] CRN_Y1X2 = 2'd1;
    localparam logic [1:0] CRN_Y2X1 = 2'd2;
    localparam logic [1:0] CRN_Y1X1 = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic       is_white;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic restart;
        logic load_pixel;
        logic wr_pixel;
        logic rd_above;
        logic rd_corner;
        logic [1:0] corner;
        logic eval_start;
        logic advance_out;
    } amt_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic pix_accepting;
        logic out_pending;
        logic win_ready;
        logic frame_done;
        logic div_done;
        logic last;
    } amt_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/adaptive_mean_threshold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_mean_threshold
// Items are taken one at a time; a new item is accepted only when the last
// one is through. An item that releases a result waits on the four
// sequential window reads of the integral row store, the 28-step serial
// divider and m_ready. Results leave in raster order; drain items flush the
// frame tail. A register write restarts the frame.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024,
    parameter int unsigned ROW_STORE  = 32,
    parameter int unsigned MAX_HALF   = 15
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [10:0]         cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire amt_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output amt_pkg::out_item_t       m_data
);
    logic [10:0] width_reg, height_reg;
    logic [3:0]  half_reg;
    logic        cfg_hit;
    amt_pkg::amt_cmd_t  cmd;
    amt_pkg::amt_stat_t stat;

    assign cfg_hit = cfg_we && (cfg_index == amt_pkg::REG_WIDTH
                             || cfg_index == amt_pkg::REG_HEIGHT
                             || cfg_index == amt_pkg::REG_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
            half_reg   <= 4'd7;
        end else if (cfg_we) begin
            unique case (cfg_index)
                amt_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                amt_pkg::REG_HEIGHT: height_reg <= cfg_data;
                amt_pkg::REG_HALF:   half_reg   <= cfg_data[3:0];
                default: begin end
            endcase
        end
    end

    amt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_hit (cfg_hit),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_data.cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    amt_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_STORE  (ROW_STORE),
        .MAX_HALF   (MAX_HALF)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .half_window  (half_reg),
        .in_item      (s_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (m_data)
    );
endmodule
`default_nettype wire

@@ rtl/core/amt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amt_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [27:0] dividend,
    input  wire logic [27:0] divisor,
    output logic             done,
    output logic [27:0]      quotient
);
    logic [27:0] rem_reg, rem_next;
    logic [27:0] quo_reg, quo_next;
    logic [27:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [28:0] trial;

    always_comb begin
        trial = {rem_reg, quo_reg[27]} - {1'b0, den_reg};
        if (!trial[28]) begin
            rem_next = trial[27:0];
            quo_next = {quo_reg[26:0], 1'b1};
        end else begin
            rem_next = {rem_reg[26:0], quo_reg[27]};
            quo_next = {quo_reg[26:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd27) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = (den_reg == '0) ? '0 : quo_reg;
endmodule
`default_nettype wire

@@ rtl/core/amt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_datapath
// Counters, row stores, window arithmetic and divider of the threshold block.
// ----------------------------------------------------------------------------
module amt_datapath #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024,
    parameter int unsigned ROW_STORE  = 32,
    parameter int unsigned MAX_HALF   = 15
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [10:0]          image_width,
    input  wire logic [10:0]          image_height,
    input  wire logic [3:0]           half_window,
    input  wire amt_pkg::in_item_t    in_item,
    input  wire amt_pkg::amt_cmd_t    cmd,
    output amt_pkg::amt_stat_t        stat,
    output amt_pkg::out_item_t        result
);
    localparam int unsigned DEPTH = ROW_STORE * MAX_WIDTH;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned HW = $clog2(MAX_HALF + 1);
    localparam int unsigned LW = CW + RW;
    // divide by three as multiply by 683 and shift right by 11
    localparam logic [19:0] DIV3_RECIP = 20'd683;

    logic [amt_pkg::INT_W-1:0]  int_mem [DEPTH];
    logic [amt_pkg::GRAY_W-1:0] gray_mem [DEPTH];

    logic [CW-1:0] w, in_col_reg, out_col_reg;
    logic [RW-1:0] h, in_row_reg, out_row_reg;
    logic [HW-1:0] hw;
    logic [LW-1:0] in_lin_reg, out_lin_reg;
    logic [amt_pkg::RSUM_W-1:0] rsum_reg;
    logic [amt_pkg::INT_W-1:0]  rd_reg, acc_reg;
    logic [amt_pkg::GRAY_W-1:0] gray_in_reg, gray_out_reg;
    logic [CW-1:0] x1, x2;
    logic [RW-1:0] y1, y2;
    logic [LW-1:0] lin2, rd_lin, wr_lin;
    logic [CW+RW-1:0] count_full;
    logic [27:0]   quotient;
    logic          div_done;
    logic [9:0]    gray_sum;
    logic [19:0]   gray_prod;

    always_comb begin
        w  = (image_width < 11'd2) ? CW'(2)
           : (image_width > 11'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
        h  = (image_height < 11'd2) ? RW'(2)
           : (image_height > 11'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(image_height);
        hw = (half_window < 4'd1) ? HW'(1)
           : ({1'b0, half_window} > 5'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(half_window);
        x1 = (out_col_reg > CW'(hw)) ? out_col_reg - CW'(hw) - CW'(1) : '0;
        y1 = (out_row_reg > RW'(hw)) ? out_row_reg - RW'(hw) - RW'(1) : '0;
        x2 = ((CW+1)'(out_col_reg) + (CW+1)'(hw) >= (CW+1)'(w))
           ? w - CW'(1) : out_col_reg + CW'(hw);
        y2 = ((RW+1)'(out_row_reg) + (RW+1)'(hw) >= (RW+1)'(h))
           ? h - RW'(1) : out_row_reg + RW'(hw);
        lin2 = LW'(y2) * LW'(w) + LW'(x2);
        unique case (cmd.corner)
            amt_pkg::CRN_Y2X2: rd_lin = lin2;
            amt_pkg::CRN_Y1X2: rd_lin = LW'(y1) * LW'(w) + LW'(x2);
            amt_pkg::CRN_Y2X1: rd_lin = LW'(y2) * LW'(w) + LW'(x1);
            default:           rd_lin = LW'(y1) * LW'(w) + LW'(x1);
        endcase
        if (cmd.rd_above) rd_lin = in_lin_reg - LW'(w);
        wr_lin = in_lin_reg;
        count_full = (CW+RW)'(x2 - x1) * (CW+RW)'(y2 - y1);
        gray_sum = 10'(in_item.red) + 10'(in_item.green) + 10'(in_item.blue);
        gray_prod = 20'(gray_sum) * DIV3_RECIP;
    end

    // memory ports
    always_ff @(posedge aclk) begin
        rd_reg       <= int_mem[AW'(rd_lin % LW'(DEPTH))];
        gray_out_reg <= gray_mem[AW'(out_lin_reg % LW'(DEPTH))];
        if (cmd.wr_pixel) begin
            int_mem[AW'(wr_lin % LW'(DEPTH))] <=
                ((in_row_reg != '0) ? rd_reg : '0) + amt_pkg::INT_W'(
                    ((in_col_reg == '0) ? '0 : rsum_reg) + amt_pkg::RSUM_W'(gray_in_reg));
            gray_mem[AW'(wr_lin % LW'(DEPTH))] <= gray_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            in_lin_reg  <= '0;
            out_lin_reg <= '0;
            rsum_reg    <= '0;
        end else begin
            if (cmd.load_pixel) begin
                gray_in_reg <= gray_prod[18:11];
            end
            if (cmd.wr_pixel) begin
                rsum_reg <= ((in_col_reg == '0) ? '0 : rsum_reg)
                          + amt_pkg::RSUM_W'(gray_in_reg);
                in_lin_reg <= in_lin_reg + LW'(1);
                if (in_col_reg + CW'(1) >= w) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (cmd.advance_out) begin
                out_lin_reg <= out_lin_reg + LW'(1);
                if (out_col_reg + CW'(1) >= w) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                end else begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // corner reads accumulate the window sum
    always_ff @(posedge aclk) begin
        if (cmd.rd_corner) begin
            if (cmd.corner == amt_pkg::CRN_Y1X2) begin
                acc_reg <= rd_reg;
            end else begin
                acc_reg <= acc_reg - rd_reg;
            end
        end
    end

    amt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.eval_start),
        .dividend (acc_reg + rd_reg),
        .divisor  (28'(count_full)),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        stat.pix_accepting = in_row_reg < h;
        stat.out_pending   = (out_row_reg < h) && (out_col_reg < w);
        stat.win_ready     = (in_row_reg >= h) || (lin2 < in_lin_reg);
        stat.frame_done    = !((out_row_reg < h) && (out_col_reg < w));
        stat.div_done      = div_done;
        stat.last          = (out_col_reg == w - CW'(1)) && (out_row_reg == h - RW'(1));
        result.is_white    = 28'(gray_out_reg) >= quotient;
        result.col         = 10'(out_col_reg);
        result.row         = 10'(out_row_reg);
        result.last        = stat.last;
    end
endmodule
`default_nettype wire

@@ rtl/core/amt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_ctrl
// Sequencer: pixel write, window reads, divide and result hand-off.
// ----------------------------------------------------------------------------
module amt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_hit,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire amt_pkg::amt_stat_t stat,
    output amt_pkg::amt_cmd_t       cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_ABOVE, ST_WRITE, ST_CHECK, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
        ST_LAST, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic   pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pix_reg   <= 1'b0;
        end else if (cfg_hit) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE:  if (s_valid) begin
                    pix_reg   <= !s_cmd && stat.pix_accepting;
                    state_reg <= (!s_cmd && stat.pix_accepting) ? ST_ABOVE : ST_CHECK;
                end
                ST_ABOVE: state_reg <= ST_WRITE;
                ST_WRITE: state_reg <= ST_CHECK;
                ST_CHECK: state_reg <= (stat.out_pending && stat.win_ready) ? ST_RD0
                                     : ST_IDLE;
                ST_RD0:   state_reg <= ST_RD1;
                ST_RD1:   state_reg <= ST_RD2;
                ST_RD2:   state_reg <= ST_RD3;
                ST_RD3:   state_reg <= ST_LAST;
                ST_LAST:  state_reg <= ST_DIV;
                ST_DIV:   if (stat.div_done) state_reg <= ST_OUT;
                ST_OUT:   if (m_ready) state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        s_ready = (state_reg == ST_IDLE) && !cfg_hit;
        m_valid = state_reg == ST_OUT;
        cmd.restart = cfg_hit
                   || (state_reg == ST_CHECK && stat.frame_done)
                   || (state_reg == ST_OUT && m_ready && stat.last);
        cmd.load_pixel = s_ready && s_valid;
        unique case (state_reg)
            ST_ABOVE: begin cmd.rd_above = 1'b1; end
            ST_WRITE: begin cmd.wr_pixel = pix_reg; end
            ST_RD0:   begin cmd.rd_corner = 1'b1; cmd.corner = amt_pkg::CRN_Y1X2; end
            ST_RD1:   begin cmd.rd_corner = 1'b1; cmd.corner = amt_pkg::CRN_Y2X1; end
            ST_RD2:   begin cmd.rd_corner = 1'b1; cmd.corner = amt_pkg::CRN_Y1X1; end
            ST_RD3:   begin cmd.corner = amt_pkg::CRN_Y1X1; end
            ST_LAST:  begin cmd.eval_start = 1'b1; end
            default:  begin end
        endcase
        cmd.advance_out = state_reg == ST_OUT && m_ready && !stat.last;
    end
endmodule
`default_nettype wire

@@ tb/adaptive_mean_threshold_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_mean_threshold_test
// Self-checking bench for the adaptive mean threshold block. A behavioural
// predictor keeps its own integral image and gray store, and every pixel or
// drain item sent adds at most one expected classification. Results are
// compared field by field in order. Frames of several sizes and window
// settings are run, including the smallest settings, the largest width and
// window, aborted frames, surplus pixels and random idling on both channels.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold_test;

    localparam int unsigned MAXW = 1024;
    localparam int unsigned MAXH = 1024;
    localparam int unsigned MAXHALF = 15;
    localparam int unsigned DEPTH = 32 * 1024;
    localparam int unsigned SETTLE = 80;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    amt_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    amt_pkg::out_item_t m_data;

    // predictor state
    logic [27:0] integ_store [DEPTH];
    logic [7:0] gray_store [DEPTH];
    logic [17:0] row_sum;
    int unsigned pix_col, pix_row, cls_col, cls_row;
    logic [10:0] width_reg, height_reg;
    logic [3:0] half_reg;

    amt_pkg::out_item_t pending_q[$];
    int unsigned fail_count = 0;
    int unsigned rx_wait = 0;
    bit stall_enable = 1'b1;

    always #2 aclk = ~aclk;

    adaptive_mean_threshold u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void frame_restart();
        row_sum = '0;
        pix_col = 0;
        pix_row = 0;
        cls_col = 0;
        cls_row = 0;
    endfunction

    // integral image update and window classification for one item
    function automatic void classify_item(amt_pkg::in_item_t it);
        int unsigned w, h, hw, g, n, x1, y1, x2, y2, cnt, mean;
        logic [27:0] above, s;
        amt_pkg::out_item_t r;
        w = clamp(width_reg, 2, MAXW);
        h = clamp(height_reg, 2, MAXH);
        hw = clamp(half_reg, 1, MAXHALF);
        if (it.cmd == 1'b0 && pix_row < h) begin
            g = (int'(it.red) + int'(it.green) + int'(it.blue)) / 3;
            n = pix_row * w + pix_col;
            above = '0;
            if (pix_col == 0) row_sum = '0;
            row_sum = row_sum + 18'(g);
            if (pix_row > 0) above = integ_store[(n - w) % DEPTH];
            integ_store[n % DEPTH] = above + 28'(row_sum);
            gray_store[n % DEPTH] = 8'(g);
            pix_col++;
            if (pix_col >= w) begin
                pix_col = 0;
                pix_row++;
            end
        end
        if (cls_row >= h || cls_col >= w) begin
            frame_restart();
            return;
        end
        x1 = cls_col > hw ? cls_col - hw - 1 : 0;
        y1 = cls_row > hw ? cls_row - hw - 1 : 0;
        x2 = cls_col + hw >= w ? w - 1 : cls_col + hw;
        y2 = cls_row + hw >= h ? h - 1 : cls_row + hw;
        if (!(pix_row >= h || (y2 * w + x2) < (pix_row * w + pix_col))) return;
        s = integ_store[(y2 * w + x2) % DEPTH] - integ_store[(y1 * w + x2) % DEPTH]
            - integ_store[(y2 * w + x1) % DEPTH] + integ_store[(y1 * w + x1) % DEPTH];
        cnt = (x2 - x1) * (y2 - y1);
        mean = cnt != 0 ? s / cnt : 0;
        r.is_white = gray_store[(cls_row * w + cls_col) % DEPTH] >= mean;
        r.col = 10'(cls_col);
        r.row = 10'(cls_row);
        r.last = (cls_col == w - 1) && (cls_row == h - 1);
        pending_q.push_back(r);
        if (r.last) begin
            frame_restart();
        end else begin
            cls_col++;
            if (cls_col >= w) begin
                cls_col = 0;
                cls_row++;
            end
        end
    endfunction

    task automatic report(string what, amt_pkg::out_item_t got, amt_pkg::out_item_t exp);
        fail_count++;
        $display("mismatch %s: got w%0d c%0d r%0d l%0d, expected w%0d c%0d r%0d l%0d",
                 what, got.is_white, got.col, got.row, got.last,
                 exp.is_white, exp.col, exp.row, exp.last);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            amt_pkg::REG_WIDTH: width_reg = value;
            amt_pkg::REG_HEIGHT: height_reg = value;
            amt_pkg::REG_HALF: half_reg = value[3:0];
            default: return;
        endcase
        frame_restart();
    endtask

    task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned gap;
        gap = stall_enable ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{cmd: cmd, red: r, green: g, blue: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        classify_item('{cmd: cmd, red: r, green: g, blue: b});
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_item(1'b0, r, g, b);
    endtask

    task automatic random_pixel();
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic drain_frame();
        int unsigned guard;
        guard = 0;
        while (!(cls_col == 0 && cls_row == 0 && pix_col == 0 && pix_row == 0)
               && guard < 4000) begin
            send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            guard++;
        end
    endtask

    task automatic setup(int unsigned w, int unsigned h, int unsigned hw);
        write_reg(amt_pkg::REG_WIDTH, 11'(w));
        write_reg(amt_pkg::REG_HEIGHT, 11'(h));
        write_reg(amt_pkg::REG_HALF, 11'(hw));
    endtask

    // extremes of the colour fields on the smallest frame and window
    task automatic test_directed();
        setup(2, 2, 1);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'h00, 8'haa, 8'h55);
        drain_frame();
        // drain with nothing ready, and surplus pixels after frame input
        send_item(1'b1, 8'h00, 8'h00, 8'h00);
        repeat (4) send_pixel(8'h80, 8'h40, 8'h20);
        send_pixel(8'h01, 8'h02, 8'h03);
        send_pixel(8'h01, 8'h02, 8'h03);
        drain_frame();
        // out of range register values are clamped
        setup(0, 1, 0);
        repeat (4) random_pixel();
        drain_frame();
        // unknown register index changes nothing
        write_reg(REG_UNUSED, 11'h7ff);
        repeat (3) random_pixel();
        drain_frame();
    endtask

    // abort a frame part way through with a register write
    task automatic test_abort();
        setup(5, 4, 2);
        repeat (7) random_pixel();
        write_reg(amt_pkg::REG_HALF, 11'd3);
        repeat (20) random_pixel();
        drain_frame();
    endtask

    // pixel stream with results drained mid frame under a sender hold-off
    task automatic test_holdoff();
        setup(6, 5, 1);
        repeat (15) random_pixel();
        wait_drained();
        repeat (15) random_pixel();
        drain_frame();
    endtask

    // a wide frame cut short at the largest width and window, and one tall frame
    task automatic test_extremes();
        setup(1024, 2, 15);
        repeat (1100) send_pixel(8'hff, 8'($urandom), 8'h00);
        setup(2, 40, 15);
        repeat (80) random_pixel();
        drain_frame();
    endtask

    // random frames with random sizes, some early drains and idle stretches
    task automatic test_random();
        int unsigned sent, w, h, npix;
        sent = 0;
        while (sent < 150) begin
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 10);
            setup(w, h, $urandom_range(1, 15));
            stall_enable = ($urandom_range(0, 3) != 0);
            npix = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w * h) : w * h;
            for (int unsigned i = 0; i < npix; i++) begin
                if ($urandom_range(0, 15) == 0) send_item(1'b1, 8'($urandom), 8'h00, 8'hff);
                else random_pixel();
                sent++;
            end
            drain_frame();
        end
        stall_enable = 1'b1;
    endtask

    // result checker with random receive stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected", m_data, '0);
            end else begin
                if (m_data !== pending_q[0]) report("field", m_data, pending_q[0]);
                void'(pending_q.pop_front());
            end
            rx_wait = stall_enable ? $urandom_range(0, 3) : 0;
        end else if (m_valid && rx_wait != 0) begin
            rx_wait--;
        end
        m_ready <= (rx_wait == 0);
    end

    initial begin
        width_reg = 11'd640;
        height_reg = 11'd480;
        half_reg = 4'd7;
        frame_restart();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_abort();
        test_holdoff();
        test_extremes();
        test_random();
        wait_drained();
        if (fail_count == 0) begin
            $display("adaptive_mean_threshold regression: pass");
        end else begin
            $display("adaptive_mean_threshold regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("adaptive_mean_threshold regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/amt_pkg.sv
rtl/core/amt_div.sv
rtl/core/amt_datapath.sv
rtl/core/amt_ctrl.sv
rtl/core/adaptive_mean_threshold.sv
tb/adaptive_mean_threshold_test.sv
